>>> design/spcl_pkg.sv
package spcl_pkg;

    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_KERNEL   = 7;
    localparam int DEF_MAX_FILTERS  = 8;

    localparam int SUM_W = 40;
    localparam int VAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_CHANNELS      = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KERNEL_WIDTH  = 3'd4,
        REG_NUM_FILTERS   = 3'd5,
        REG_ROW_STRIDE    = 3'd6,
        REG_COL_STRIDE    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [6:0] image_height;
        logic [6:0] image_width;
        logic [2:0] channels;
        logic [2:0] kernel_height;
        logic [2:0] kernel_width;
        logic [3:0] num_filters;
        logic [6:0] row_stride;
        logic [6:0] col_stride;
    } cfg_t;

    // Compute request passed from front to back
    typedef struct packed {
        logic        err;
        logic [2:0]  filter_index;
        logic [12:0] centre_row;
        logic [12:0] centre_col;
    } job_t;

endpackage

>>> design/spcl_if.sv
interface spcl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  filter_index;
    logic [1:0]  channel_index;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic signed [15:0] sample_value;
    modport source (output valid, op, filter_index, channel_index, row_index, col_index,
                    sample_value, input ready);
    modport sink (input valid, op, filter_index, channel_index, row_index, col_index,
                  sample_value, output ready);
endinterface

interface spcl_out_if;
    logic        valid;
    logic        ready;
    logic signed [39:0] conv_sum;
    logic        position_error;
    modport source (output valid, conv_sum, position_error, input ready);
    modport sink (input valid, conv_sum, position_error, output ready);
endinterface

interface spcl_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/spcl_front.sv
module spcl_front #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_FILTERS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    spcl_in_if.sink           in_ch,
    input  spcl_pkg::cfg_t    cfg,
    input  logic              back_busy,
    output logic              img_we,
    output logic              wgt_we,
    output logic              job_valid,
    input  logic              job_ready,
    output spcl_pkg::job_t    job
);
    import spcl_pkg::*;

    logic [6:0]  h_eff, w_eff, rs, cs;
    logic [3:0]  nf;
    logic [12:0] cr, cc;
    logic        q_valid_reg, q_valid_next;
    job_t        q_reg, q_next;
    logic        is_compute, accept;

    assign h_eff = (cfg.image_height == 7'd0) ? 7'd1 :
                   (32'(cfg.image_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg.image_height;
    assign w_eff = (cfg.image_width == 7'd0) ? 7'd1 :
                   (32'(cfg.image_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg.image_width;
    assign nf    = (cfg.num_filters == 4'd0) ? 4'd1 :
                   (32'(cfg.num_filters) > MAX_FILTERS) ? 4'(MAX_FILTERS) : cfg.num_filters;
    assign rs = (cfg.row_stride == 7'd0) ? 7'd1 : cfg.row_stride;
    assign cs = (cfg.col_stride == 7'd0) ? 7'd1 : cfg.col_stride;
    assign cr = 13'(in_ch.row_index) * 13'(rs);
    assign cc = 13'(in_ch.col_index) * 13'(cs);

    assign is_compute = (op_t'(in_ch.op) == OP_COMPUTE);
    // queue one job while the back works on another; hold writes until every
    // earlier compute request has finished reading the memories
    assign in_ch.ready = is_compute ? (!q_valid_reg || job_ready)
                                    : (!q_valid_reg && !back_busy);
    assign accept = in_ch.valid && in_ch.ready;
    assign img_we = accept && (op_t'(in_ch.op) == OP_SAMPLE);
    assign wgt_we = accept && (op_t'(in_ch.op) == OP_WEIGHT);

    always_comb
    begin
        q_valid_next = q_valid_reg && !job_ready;
        q_next = q_reg;
        if (accept && is_compute)
        begin
            q_valid_next = 1'b1;
            q_next.filter_index = in_ch.filter_index;
            q_next.centre_row = cr;
            q_next.centre_col = cc;
            q_next.err = (4'(in_ch.filter_index) >= nf) || (cr >= 13'(h_eff))
                         || (cc >= 13'(w_eff));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign job_valid = q_valid_reg;
    assign job = q_reg;

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && !q_reg.err |-> q_reg.centre_row < 13'(MAX_HEIGHT))
        else $error("queued job centre beyond image");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && !job_ready |=> q_valid_reg && $stable(q_reg))
        else $error("queued job lost");
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && !job_ready && is_compute |-> !in_ch.ready)
        else $error("compute taken while queue full");

endmodule

>>> design/spcl_back.sv
module spcl_back #(
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_FILTERS  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    spcl_in_if.sink           wr,
    input  logic              img_we,
    input  logic              wgt_we,
    input  spcl_pkg::cfg_t    cfg,
    input  logic              job_valid,
    output logic              job_ready,
    output logic              busy,
    input  spcl_pkg::job_t    job,
    spcl_out_if.source        out_ch
);
    import spcl_pkg::*;

    localparam int IMG_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    logic [VAL_W-1:0] img_mem [IMG_DEPTH];
    logic [VAL_W-1:0] wgt_mem [WGT_DEPTH];

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [3:0]  k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [3:0]  nc, kh, kw;
    logic [2:0]  khc, kwc;
    logic signed [13:0] ir, ic;
    logic [6:0]  h_eff, w_eff;
    logic        tap_ok, last_tap;
    logic        rd_v_reg, p_v_reg;
    logic signed [VAL_W-1:0] s_reg, w_reg;
    logic signed [31:0] p_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic        out_v_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic        out_err_reg;
    logic [IAW-1:0] iaddr;
    logic [WAW-1:0] waddr;
    logic [IAW-1:0] wr_iaddr;
    logic [WAW-1:0] wr_waddr;

    assign h_eff = (cfg.image_height == 7'd0) ? 7'd1 :
                   (32'(cfg.image_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg.image_height;
    assign w_eff = (cfg.image_width == 7'd0) ? 7'd1 :
                   (32'(cfg.image_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg.image_width;
    assign nc  = (cfg.channels == 3'd0) ? 4'd1 :
                 (32'(cfg.channels) > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : 4'(cfg.channels);
    assign khc = (cfg.kernel_height == 3'd0) ? 3'd1 :
                 (32'(cfg.kernel_height) > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg.kernel_height;
    assign kwc = (cfg.kernel_width == 3'd0) ? 3'd1 :
                 (32'(cfg.kernel_width) > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg.kernel_width;
    // an even size drops to the odd size below it
    assign kh = khc[0] ? {1'b0, khc} : {1'b0, khc - 3'd1};
    assign kw = kwc[0] ? {1'b0, kwc} : {1'b0, kwc - 3'd1};

    // write side
    assign wr_iaddr = IAW'((32'(wr.channel_index) * MAX_HEIGHT + 32'(wr.row_index))
                      * MAX_WIDTH + 32'(wr.col_index));
    assign wr_waddr = WAW'(((32'(wr.filter_index) * MAX_CHANNELS + 32'(wr.channel_index))
                      * MAX_KERNEL + 32'(wr.row_index)) * MAX_KERNEL + 32'(wr.col_index));

    always_ff @(posedge clk)
    begin
        if (img_we && 32'(wr.channel_index) < MAX_CHANNELS && 32'(wr.row_index) < MAX_HEIGHT
            && 32'(wr.col_index) < MAX_WIDTH)
            img_mem[wr_iaddr] <= wr.sample_value;
        if (wgt_we && 32'(wr.filter_index) < MAX_FILTERS
            && 32'(wr.channel_index) < MAX_CHANNELS
            && 32'(wr.row_index) < MAX_KERNEL && 32'(wr.col_index) < MAX_KERNEL)
            wgt_mem[wr_waddr] <= wr.sample_value;
    end

    // tap walk: channel k, kernel row i, kernel column j
    assign ir = $signed({1'b0, job_reg.centre_row}) + $signed({10'd0, i_reg})
                - $signed({11'd0, kh[3:1]});
    assign ic = $signed({1'b0, job_reg.centre_col}) + $signed({10'd0, j_reg})
                - $signed({11'd0, kw[3:1]});
    assign tap_ok = (ir >= 0) && (ir < $signed({7'd0, h_eff}))
                    && (ic >= 0) && (ic < $signed({7'd0, w_eff}));
    assign last_tap = (j_reg == kw - 4'd1) && (i_reg == kh - 4'd1) && (k_reg == nc - 4'd1);
    assign iaddr = IAW'((32'(k_reg) * MAX_HEIGHT + 32'(ir[12:0])) * MAX_WIDTH
                   + 32'(ic[12:0]));
    assign waddr = WAW'(((32'(job_reg.filter_index) * MAX_CHANNELS + 32'(k_reg))
                   * MAX_KERNEL + 32'(i_reg)) * MAX_KERNEL + 32'(j_reg));

    always_ff @(posedge clk)
    begin
        s_reg <= img_mem[iaddr];
        w_reg <= wgt_mem[waddr];
        p_reg <= s_reg * w_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) state_next = job.err ? ST_OUT : ST_RUN;
            ST_RUN:   if (last_tap) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_v_reg && !p_v_reg) state_next = ST_OUT;
            ST_OUT:   if (!out_v_reg || out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        sum_next = p_v_reg ? sum_reg + SUM_W'(p_reg) : sum_reg;
        job_ready = (state_reg == ST_IDLE);
        if (state_reg == ST_IDLE)
        begin
            k_next = '0;
            i_next = '0;
            j_next = '0;
            sum_next = '0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (j_reg == kw - 4'd1)
            begin
                j_next = '0;
                if (i_reg == kh - 4'd1)
                begin
                    i_next = '0;
                    k_next = k_reg + 4'd1;
                end
                else
                    i_next = i_reg + 4'd1;
            end
            else
                j_next = j_reg + 4'd1;
        end
    end

    assign busy = (state_reg == ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == ST_RUN) && tap_ok;
            p_v_reg   <= rd_v_reg;
            if (state_reg == ST_OUT && (!out_v_reg || out_ch.ready))
                out_v_reg <= 1'b1;
            else if (out_ch.ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        i_reg <= i_next;
        j_reg <= j_next;
        sum_reg <= sum_next;
        if (state_reg == ST_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == ST_OUT && (!out_v_reg || out_ch.ready))
        begin
            out_sum_reg <= job_reg.err ? '0 : sum_reg;
            out_err_reg <= job_reg.err;
        end
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.conv_sum = out_sum_reg;
    assign out_ch.position_error = out_err_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_ch.ready |=> out_v_reg && $stable(out_sum_reg))
        else $error("result dropped under stall");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> !rd_v_reg && !p_v_reg)
        else $error("result sent before sum complete");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !p_v_reg)
        else $error("product arrived while idle");

endmodule

>>> design/same_padded_conv_layer_top.sv
// Same-padded multichannel 2-D convolution.
// Channels: in (op, filter, channel, row, col, sample), out (conv_sum,
// position_error), cfg (index, 7-bit data). All are valid/ready; a request
// moves when both are high.
// Weight and sample writes give no result; they wait while a compute
// request is queued or its tap walk is running. A compute request enters
// a one-entry queue; the back end walks channels x kernel rows x kernel
// columns, one tap per cycle through one multiplier and one read port.
// Results leave from an output register; while out.ready is low the result
// holds and the back end waits, and the front keeps taking one queued
// compute request, and write requests while no compute is queued.
// Reset: registers take 64, 64, 1, 3, 3, 1, 1, 1; queue and result clear.
// Image and weight memories are not cleared; read only written entries.
// Configuration is taken at any time but must change only when idle.
module same_padded_conv_layer_top #(
    parameter int MAX_HEIGHT   = spcl_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = spcl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = spcl_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = spcl_pkg::DEF_MAX_KERNEL,
    parameter int MAX_FILTERS  = spcl_pkg::DEF_MAX_FILTERS
) (
    input  logic      clk,
    input  logic      rst_n,
    spcl_in_if.sink   in_ch,
    spcl_cfg_if.sink  cfg_ch,
    spcl_out_if.source out_ch
);
    import spcl_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  img_we, wgt_we, job_valid, job_ready, back_busy;
    job_t  job;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (reg_idx_t'(cfg_ch.index))
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_ch.data;
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_ch.data;
                REG_CHANNELS:      cfg_next.channels      = cfg_ch.data[2:0];
                REG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_ch.data[2:0];
                REG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_ch.data[2:0];
                REG_NUM_FILTERS:   cfg_next.num_filters   = cfg_ch.data[3:0];
                REG_ROW_STRIDE:    cfg_next.row_stride    = cfg_ch.data;
                REG_COL_STRIDE:    cfg_next.col_stride    = cfg_ch.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height  <= 7'd64;
            cfg_reg.image_width   <= 7'd64;
            cfg_reg.channels      <= 3'd1;
            cfg_reg.kernel_height <= 3'd3;
            cfg_reg.kernel_width  <= 3'd3;
            cfg_reg.num_filters   <= 4'd1;
            cfg_reg.row_stride    <= 7'd1;
            cfg_reg.col_stride    <= 7'd1;
        end
        else
            cfg_reg <= cfg_next;
    end

    spcl_front #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FILTERS(MAX_FILTERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg_reg),
        .back_busy(back_busy),
        .img_we   (img_we),
        .wgt_we   (wgt_we),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job      (job)
    );

    spcl_back #(
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_FILTERS (MAX_FILTERS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (in_ch),
        .img_we   (img_we),
        .wgt_we   (wgt_we),
        .cfg      (cfg_reg),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .busy     (back_busy),
        .job      (job),
        .out_ch   (out_ch)
    );

endmodule

>>> dv/same_padded_conv_layer_top_tb.sv
`timescale 1ns / 1ps

module same_padded_conv_layer_top_tb;
    import spcl_pkg::*;

    typedef struct {
        logic signed [39:0] conv_sum;
        logic               position_error;
    } conv_result_t;

    localparam int IMG_DEPTH = 4 * 64 * 64;
    localparam int WGT_DEPTH = 8 * 4 * 7 * 7;
    localparam int SETTLE_CYCLES = 220;

    logic clk;
    logic rst_n;

    spcl_in_if  in_if();
    spcl_cfg_if cfg_if();
    spcl_out_if out_if();

    same_padded_conv_layer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .cfg_ch (cfg_if),
        .out_ch (out_if)
    );

    // Shadow copy of the block's state
    logic [15:0] image_mem [IMG_DEPTH];
    logic [15:0] weight_mem [WGT_DEPTH];
    logic [6:0]  cfg_regs [8];

    conv_result_t expected_sums[$];
    int unsigned  mismatches;
    int unsigned  hold_off;
    bit           no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("same_padded_conv_layer_top_tb NOT OK");
        $finish;
    end

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int odd_size(int v);
        int k;
        k = clamp_to(v, 1, 7);
        if (k % 2 == 0)
            k = k - 1;
        return k;
    endfunction

    function automatic conv_result_t conv_at(int f, int r, int c);
        conv_result_t res;
        int h, w, nc, nf, kh, kw, rs, cs, cr, cc, ir, ic;
        longint acc;
        longint s;
        longint wv;
        h  = clamp_to(cfg_regs[REG_IMAGE_HEIGHT], 1, 64);
        w  = clamp_to(cfg_regs[REG_IMAGE_WIDTH], 1, 64);
        nc = clamp_to(cfg_regs[REG_CHANNELS] & 7, 1, 4);
        nf = clamp_to(cfg_regs[REG_NUM_FILTERS] & 15, 1, 8);
        kh = odd_size(cfg_regs[REG_KERNEL_HEIGHT] & 7);
        kw = odd_size(cfg_regs[REG_KERNEL_WIDTH] & 7);
        rs = cfg_regs[REG_ROW_STRIDE] == 0 ? 1 : cfg_regs[REG_ROW_STRIDE];
        cs = cfg_regs[REG_COL_STRIDE] == 0 ? 1 : cfg_regs[REG_COL_STRIDE];
        cr = r * rs;
        cc = c * cs;
        acc = 0;
        res.position_error = 1'b0;
        if (f >= nf || cr >= h || cc >= w)
        begin
            res.conv_sum = '0;
            res.position_error = 1'b1;
            return res;
        end
        for (int k = 0; k < nc; k++)
            for (int i = 0; i < kh; i++)
            begin
                ir = cr + i - kh / 2;
                if (ir < 0 || ir >= h)
                    continue;
                for (int j = 0; j < kw; j++)
                begin
                    ic = cc + j - kw / 2;
                    if (ic < 0 || ic >= w)
                        continue;
                    s  = $signed(image_mem[(k * 64 + ir) * 64 + ic]);
                    wv = $signed(weight_mem[((f * 4 + k) * 7 + i) * 7 + j]);
                    acc += s * wv;
                end
            end
        res.conv_sum = acc[39:0];
        return res;
    endfunction

    function automatic void apply_request(op_t op, int f, int ch, int r, int c,
                                          logic [15:0] v);
        case (op)
            OP_WEIGHT:
                if (r < 7 && c < 7)
                    weight_mem[((f * 4 + ch) * 7 + r) * 7 + c] = v;
            OP_SAMPLE:
                image_mem[(ch * 64 + r) * 64 + c] = v;
            OP_COMPUTE:
                expected_sums.push_back(conv_at(f, r, c));
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'h8000;
        if (sel == 1)
            return 16'h7fff;
        return 16'($urandom);
    endfunction

    task automatic send_request(op_t op, int f, int ch, int r, int c, logic [15:0] v);
        if (!no_idle && $urandom_range(0, 99) < 34)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.op            <= op;
        in_if.filter_index  <= 3'(f);
        in_if.channel_index <= 2'(ch);
        in_if.row_index     <= 6'(r);
        in_if.col_index     <= 6'(c);
        in_if.sample_value  <= v;
        do @(posedge clk); while (!in_if.ready);
        apply_request(op, f, ch, r, c, v);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [6:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_regs[idx] = data;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop input valid, then let the back end finish before touching registers
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_shape(int h, int w, int ch, int kh, int kw, int nf, int rs, int cs);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 7'(h));
        write_reg(REG_IMAGE_WIDTH, 7'(w));
        write_reg(REG_CHANNELS, 7'(ch));
        write_reg(REG_KERNEL_HEIGHT, 7'(kh));
        write_reg(REG_KERNEL_WIDTH, 7'(kw));
        write_reg(REG_NUM_FILTERS, 7'(nf));
        write_reg(REG_ROW_STRIDE, 7'(rs));
        write_reg(REG_COL_STRIDE, 7'(cs));
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Receiver: check accepted results, then pick next ready
    initial
    begin
        conv_result_t want;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch("unexpected result", out_if.conv_sum, 0);
                else
                begin
                    want = expected_sums.pop_front();
                    if (out_if.conv_sum !== want.conv_sum)
                        report_mismatch("conv_sum", out_if.conv_sum, want.conv_sum);
                    if (out_if.position_error !== want.position_error)
                        report_mismatch("position_error", out_if.position_error,
                                        want.position_error);
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_if.ready <= 1'b0;
            end
            else if (no_idle)
                out_if.ready <= 1'b1;
            else
                out_if.ready <= ($urandom_range(0, 99) >= 34);
        end
    end

    // Fill every entry so no compute ever reads an unwritten one
    task automatic test_fill_stores();
        no_idle = 1'b1;
        for (int ch = 0; ch < 4; ch++)
            for (int r = 0; r < 64; r++)
                for (int c = 0; c < 64; c++)
                    send_request(OP_SAMPLE, $urandom_range(0, 7), ch, r, c, pick_value());
        for (int f = 0; f < 8; f++)
            for (int ch = 0; ch < 4; ch++)
                for (int r = 0; r < 7; r++)
                    for (int c = 0; c < 7; c++)
                        send_request(OP_WEIGHT, f, ch, r, c, pick_value());
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        send_request(OP_SAMPLE, 0, 0, 0, 0, 16'h8000);
        send_request(OP_WEIGHT, 0, 0, 1, 1, 16'h8000);
        send_request(OP_COMPUTE, 0, 0, 0, 0, 16'hffff);
        send_request(OP_SAMPLE, 0, 0, 63, 63, 16'h7fff);
        send_request(OP_WEIGHT, 0, 0, 1, 1, 16'h7fff);
        send_request(OP_COMPUTE, 0, 3, 63, 63, 16'h0000);
        send_request(OP_COMPUTE, 0, 0, 0, 63, 16'h1234);
        send_request(OP_COMPUTE, 0, 0, 63, 0, 16'h1234);
        send_request(OP_COMPUTE, 0, 0, 31, 17, 16'h1234);
        // filter not in use
        send_request(OP_COMPUTE, 1, 0, 5, 5, 16'h0000);
        send_request(OP_COMPUTE, 7, 0, 5, 5, 16'h0000);
        // ignored writes: kernel row or column out of range, unused op
        send_request(OP_WEIGHT, 0, 0, 7, 0, 16'h5555);
        send_request(OP_WEIGHT, 0, 0, 0, 63, 16'haaaa);
        send_request(OP_NONE, 7, 3, 63, 63, 16'hffff);
        send_request(OP_COMPUTE, 0, 0, 1, 1, 16'h0000);
        // centre outside the image, then two centres inside it
        set_shape(10, 12, 4, 7, 7, 8, 3, 5);
        send_request(OP_COMPUTE, 2, 0, 4, 0, 16'h0000);
        send_request(OP_COMPUTE, 2, 0, 0, 3, 16'h0000);
        send_request(OP_COMPUTE, 7, 0, 3, 2, 16'h0000);
        send_request(OP_COMPUTE, 5, 0, 0, 0, 16'h0000);
    endtask

    task automatic random_requests(int count);
        int sel, rs, cs, r, c;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            rs = cfg_regs[REG_ROW_STRIDE] == 0 ? 1 : cfg_regs[REG_ROW_STRIDE];
            cs = cfg_regs[REG_COL_STRIDE] == 0 ? 1 : cfg_regs[REG_COL_STRIDE];
            if (sel < 55)
            begin
                // mostly centres inside the image, some anywhere
                if ($urandom_range(0, 3) != 0)
                begin
                    r = $urandom_range(0, (clamp_to(cfg_regs[REG_IMAGE_HEIGHT], 1, 64) - 1) / rs);
                    c = $urandom_range(0, (clamp_to(cfg_regs[REG_IMAGE_WIDTH], 1, 64) - 1) / cs);
                end
                else
                begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                end
                send_request(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 3), r, c,
                             16'($urandom));
            end
            else if (sel < 78)
                send_request(OP_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
            else if (sel < 96)
                send_request(OP_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
            else
                send_request(OP_NONE, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
        end
    endtask

    task automatic test_shapes();
        set_shape(1, 1, 1, 1, 1, 1, 1, 1);
        random_requests(40);
        set_shape(64, 64, 4, 7, 7, 8, 64, 64);
        random_requests(40);
        // out-of-range values: clamped sizes, zero strides, even kernels
        set_shape(0, 0, 0, 0, 0, 0, 0, 0);
        random_requests(30);
        set_shape(127, 127, 7, 6, 4, 15, 127, 127);
        random_requests(30);
        set_shape(17, 33, 2, 5, 3, 4, 2, 3);
        random_requests(60);
        set_shape(40, 9, 3, 2, 7, 6, 1, 1);
        random_requests(60);
    endtask

    task automatic test_backpressure();
        set_shape(20, 20, 2, 3, 3, 8, 1, 1);
        hold_off = 400;
        random_requests(30);
        no_idle = 1'b1;
        random_requests(60);
        no_idle = 1'b0;
        random_requests(60);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        in_if.valid          <= 1'b0;
        in_if.op             <= OP_NONE;
        in_if.filter_index   <= '0;
        in_if.channel_index  <= '0;
        in_if.row_index      <= '0;
        in_if.col_index      <= '0;
        in_if.sample_value   <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_IMAGE_HEIGHT;
        cfg_if.data          <= '0;
        mismatches = 0;
        hold_off   = 0;
        no_idle    = 1'b0;
        cfg_regs = '{7'd64, 7'd64, 7'd1, 7'd3, 7'd3, 7'd1, 7'd1, 7'd1};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_stores();
        test_directed();
        test_shapes();
        test_backpressure();

        wait_idle();
        if (mismatches == 0)
            $display("same_padded_conv_layer_top_tb OK");
        else
            $display("same_padded_conv_layer_top_tb NOT OK");
        $finish;
    end

endmodule
